// ===== rtl/core/sbv_pkg.sv =====
`default_nettype none
package sbv_pkg;

	localparam int CORDIC_STAGES_DEF = 16;

	localparam int MODE_W = 2;
	localparam int WB_W   = 14;
	localparam int IDX_W  = 2;
	localparam int SPD_W  = 17;
	localparam int ANG_W  = 15;
	localparam int HDG_W  = 16;
	localparam int SPIN_W = 24;
	localparam int VEL_W  = 17;
	localparam int SUM_W  = 18;

	localparam int XW    = 33;
	localparam int ZW    = 25;
	localparam int VP_W  = SPD_W + XW;
	localparam int RV_W  = VP_W - 30;
	localparam int SCP_W = 2 * XW;
	localparam int SC_W  = SCP_W - 36;
	localparam int CQ_W  = XW - 6;
	localparam int D_W   = WB_W + 1 + CQ_W;
	localparam int N_W   = SPD_W + SC_W;
	localparam int LO_W  = 23;
	localparam int HI_W  = N_W - LO_W;
	localparam int K_W   = 21;
	localparam int DW    = 76;
	localparam int QW    = 23;

	typedef enum logic [MODE_W-1:0] {
		MODE_FRONT  = 2'd0,
		MODE_AWS    = 2'd1,
		MODE_CRAB   = 2'd2,
		MODE_ROTATE = 2'd3
	} mode_t;

	localparam logic [IDX_W-1:0] REG_MODE      = 2'd0;
	localparam logic [IDX_W-1:0] REG_WHEELBASE = 2'd1;

	localparam logic [WB_W-1:0] WHEELBASE_RST = 14'd2700;
	localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic [K_W-1:0] YAW_SCALE = 21'd1877468;
	localparam logic signed [SPIN_W-1:0] YAW_MAX = 24'sd8388607;
	localparam logic signed [SPIN_W-1:0] YAW_MIN_RAW = -24'sd8388608;
	localparam logic signed [VEL_W-1:0] VEL_MAX = 17'sd65535;

	localparam logic signed [18:0] FULL_TURN    = 19'sd46080;
	localparam logic signed [18:0] HALF_TURN    = 19'sd23040;
	localparam logic signed [18:0] QUARTER_TURN = 19'sd11520;

	localparam logic [20:0] ATAN_TAB [24] = '{
		21'd1474560, 21'd870484, 21'd459940, 21'd233473, 21'd117189, 21'd58652,
		21'd29333, 21'd14667, 21'd7334, 21'd3667, 21'd1833, 21'd917,
		21'd458, 21'd229, 21'd115, 21'd57, 21'd29, 21'd14,
		21'd7, 21'd4, 21'd2, 21'd1, 21'd0, 21'd0
	};

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 neg;
	} lane_t;

	function automatic lane_t lane_init(input logic signed [SUM_W-1:0] a);
		logic signed [18:0] t;
		lane_t l;
		t = {a[SUM_W-1], a};
		if (t >= HALF_TURN) t = t - FULL_TURN;
		if (t >= HALF_TURN) t = t - FULL_TURN;
		if (t < -HALF_TURN) t = t + FULL_TURN;
		if (t < -HALF_TURN) t = t + FULL_TURN;
		l.neg = 1'b0;
		if (t > QUARTER_TURN) begin
			t = t - HALF_TURN;
			l.neg = 1'b1;
		end else if (t < -QUARTER_TURN) begin
			t = t + HALF_TURN;
			l.neg = 1'b1;
		end
		l.x = CORDIC_GAIN;
		l.y = '0;
		l.z = {t[16:0], 8'd0};
		return l;
	endfunction

	function automatic logic signed [VEL_W-1:0] vel_round(input logic signed [VP_W-1:0] p);
		logic signed [VP_W-1:0] s;
		logic signed [RV_W-1:0] r;
		s = p + VP_W'(64'd536870912);
		r = s[VP_W-1:30];
		if (r > RV_W'(VEL_MAX)) return VEL_MAX;
		if (r < -RV_W'(VEL_MAX)) return -VEL_MAX;
		return r[VEL_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sbv_cordic_cell.sv =====
`default_nettype none
module sbv_cordic_cell import sbv_pkg::*; #(
	parameter int STAGE = 0
) (
	input  wire logic  clk,
	input  wire logic  en,
	input  wire lane_t lane_i,
	output lane_t      lane_o
);

	logic signed [ZW-1:0] ang;
	lane_t nxt;

	assign ang = $signed(ZW'(ATAN_TAB[STAGE]));

	always_comb begin
		nxt = lane_i;
		if (!lane_i.z[ZW-1]) begin
			nxt.x = lane_i.x - (lane_i.y >>> STAGE);
			nxt.y = lane_i.y + (lane_i.x >>> STAGE);
			nxt.z = lane_i.z - ang;
		end else begin
			nxt.x = lane_i.x + (lane_i.y >>> STAGE);
			nxt.y = lane_i.y - (lane_i.x >>> STAGE);
			nxt.z = lane_i.z + ang;
		end
	end

	always_ff @(posedge clk) begin
		if (en) lane_o <= nxt;
	end

endmodule
`default_nettype wire

// ===== rtl/core/sbv_div_cell.sv =====
`default_nettype none
module sbv_div_cell import sbv_pkg::*; #(
	parameter int BIT = 0
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [DW-1:0] rem_i,
	input  wire logic [DW-1:0] dm_i,
	input  wire logic [QW-1:0] q_i,
	output logic [DW-1:0]      rem_o,
	output logic [DW-1:0]      dm_o,
	output logic [QW-1:0]      q_o
);

	logic [DW-1:0] trial;
	logic          take;
	logic [QW-1:0] q_nxt;

	assign trial = dm_i << BIT;
	assign take  = rem_i >= trial;

	always_comb begin
		q_nxt      = q_i;
		q_nxt[BIT] = take;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= take ? rem_i - trial : rem_i;
			dm_o  <= dm_i;
			q_o   <= q_nxt;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/steering_mode_body_velocity.sv =====
// Steering-mode body velocity: world X/Y velocity and yaw rate per command.
// Throughput: one word per cycle; the whole pipeline holds while an output
// word waits, set by the single output register at the end of the chain.
// Reset: valid bits clear, steering_mode to front steer, wheelbase to 2700 mm.
`default_nettype none
module steering_mode_body_velocity import sbv_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [IDX_W-1:0]         cfg_index,
	input  wire logic [WB_W-1:0]          cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [SPD_W-1:0]  speed,
	input  wire logic signed [ANG_W-1:0]  steer_front,
	input  wire logic signed [ANG_W-1:0]  steer_rear,
	input  wire logic signed [ANG_W-1:0]  slip_angle,
	input  wire logic signed [HDG_W-1:0]  heading,
	input  wire logic signed [HDG_W-1:0]  travel_direction,
	input  wire logic signed [SPIN_W-1:0] spin_rate,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [VEL_W-1:0]       vel_x,
	output logic signed [VEL_W-1:0]       vel_y,
	output logic signed [SPIN_W-1:0]      yaw_rate,
	output logic                          saturated
);

	typedef struct packed {
		mode_t                    mode;
		logic signed [SPD_W-1:0]  spd;
		logic signed [SPIN_W-1:0] spin;
	} cside_t;

	typedef struct packed {
		mode_t                    mode;
		logic signed [VEL_W-1:0]  vx;
		logic signed [VEL_W-1:0]  vy;
		logic signed [SPIN_W-1:0] spin;
		logic                     nz;
		logic                     dz;
		logic                     nneg;
		logic                     negr;
		logic                     ovf;
	} pside_t;

	mode_t           mode_q;
	logic [WB_W-1:0] wb_q;
	logic            en;

	assign cfg_ready = 1'b1;
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FRONT;
			wb_q   <= WHEELBASE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:      mode_q <= mode_t'(cfg_data[MODE_W-1:0]);
				REG_WHEELBASE: wb_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// entry: angle sums, wrap and fold
	logic signed [SUM_W-1:0] rear, dir_ang, num_ang, den_ang, slip_ang;

	always_comb begin
		rear     = (mode_q == MODE_AWS) ? SUM_W'(steer_rear) : '0;
		dir_ang  = (mode_q == MODE_CRAB) ? SUM_W'(travel_direction)
			: SUM_W'(heading) + rear + SUM_W'(slip_angle);
		num_ang  = SUM_W'(steer_front) - rear;
		den_ang  = SUM_W'(steer_front);
		slip_ang = SUM_W'(slip_angle);
	end

	lane_t  s0_lane [4];
	lane_t  ln [4][CORDIC_STAGES];
	cside_t cs_q [CORDIC_STAGES+1];
	logic [CORDIC_STAGES:0] cv_q;

	always_ff @(posedge clk) begin
		if (en) begin
			s0_lane[0] <= lane_init(dir_ang);
			s0_lane[1] <= lane_init(num_ang);
			s0_lane[2] <= lane_init(den_ang);
			s0_lane[3] <= lane_init(slip_ang);
			cs_q[0]    <= '{mode: mode_q, spd: speed, spin: spin_rate};
			for (int j = 1; j <= CORDIC_STAGES; j++) cs_q[j] <= cs_q[j-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cv_q <= '0;
		else if (en) cv_q <= {cv_q[CORDIC_STAGES-1:0], in_valid};
	end

	for (genvar k = 0; k < 4; k++) begin : g_lane
		for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cell
			if (j == 0) begin : g_first
				sbv_cordic_cell #(.STAGE(j)) u_cell (
					.clk(clk), .en(en), .lane_i(s0_lane[k]), .lane_o(ln[k][j])
				);
			end else begin : g_next
				sbv_cordic_cell #(.STAGE(j)) u_cell (
					.clk(clk), .en(en), .lane_i(ln[k][j-1]), .lane_o(ln[k][j])
				);
			end
		end
	end

	// s1: sign fix and products
	logic signed [XW-1:0] c_dir, s_dir, s_num, c_den, c_slp;
	logic signed [XW-1:0] cq_sum;
	cside_t                c1_s1;
	logic                  v_s1;
	logic signed [VP_W-1:0]  vxp_s1, vyp_s1;
	logic signed [SCP_W-1:0] scp_s1;
	logic signed [CQ_W-1:0]  cq_s1;

	always_comb begin
		c_dir  = ln[0][CORDIC_STAGES-1].neg ? -ln[0][CORDIC_STAGES-1].x : ln[0][CORDIC_STAGES-1].x;
		s_dir  = ln[0][CORDIC_STAGES-1].neg ? -ln[0][CORDIC_STAGES-1].y : ln[0][CORDIC_STAGES-1].y;
		s_num  = ln[1][CORDIC_STAGES-1].neg ? -ln[1][CORDIC_STAGES-1].y : ln[1][CORDIC_STAGES-1].y;
		c_den  = ln[2][CORDIC_STAGES-1].neg ? -ln[2][CORDIC_STAGES-1].x : ln[2][CORDIC_STAGES-1].x;
		c_slp  = ln[3][CORDIC_STAGES-1].neg ? -ln[3][CORDIC_STAGES-1].x : ln[3][CORDIC_STAGES-1].x;
		cq_sum = c_den + XW'(32);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c1_s1  <= cs_q[CORDIC_STAGES];
			vxp_s1 <= cs_q[CORDIC_STAGES].spd * c_dir;
			vyp_s1 <= cs_q[CORDIC_STAGES].spd * s_dir;
			scp_s1 <= s_num * c_slp;
			cq_s1  <= cq_sum[XW-1:6];
		end
	end

	// s2: rounding, wheelbase product
	logic signed [SCP_W-1:0] sc_sum;
	cside_t                  c2_s2;
	logic                    v_s2;
	logic signed [VEL_W-1:0] vx_s2, vy_s2;
	logic signed [SC_W-1:0]  sc_s2;
	logic signed [D_W-1:0]   d_s2;

	assign sc_sum = scp_s1 + SCP_W'(68'd34359738368);

	always_ff @(posedge clk) begin
		if (en) begin
			c2_s2 <= c1_s1;
			vx_s2 <= vel_round(vxp_s1);
			vy_s2 <= vel_round(vyp_s1);
			sc_s2 <= sc_sum[SCP_W-1:36];
			d_s2  <= $signed({1'b0, wb_q}) * cq_s1;
		end
	end

	// s3: numerator
	logic signed [N_W-1:0]   n_s3;
	logic signed [D_W-1:0]   d_s3;
	logic signed [VEL_W-1:0] vx_s3, vy_s3;
	logic signed [SPIN_W-1:0] spin_s3;
	mode_t                   mode_s3;
	logic                    v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s3    <= c2_s2.spd * sc_s2;
			d_s3    <= d_s2;
			vx_s3   <= vx_s2;
			vy_s3   <= vy_s2;
			spin_s3 <= c2_s2.spin;
			mode_s3 <= c2_s2.mode;
		end
	end

	// s4: magnitudes and split scale products
	logic [N_W-1:0]  nmag;
	logic [D_W-1:0]  dmag;
	pside_t          ps_s4;
	logic            v_s4;
	logic [LO_W+K_W-1:0] pl_s4;
	logic [HI_W+K_W-1:0] ph_s4;
	logic [DW-1:0]   dm_s4;

	assign nmag = n_s3[N_W-1] ? N_W'(-n_s3) : N_W'(n_s3);
	assign dmag = d_s3[D_W-1] ? D_W'(-d_s3) : D_W'(d_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			ps_s4 <= '{mode: mode_s3, vx: vx_s3, vy: vy_s3, spin: spin_s3,
				nz: n_s3 == '0, dz: d_s3 == '0, nneg: n_s3[N_W-1],
				negr: n_s3[N_W-1] != d_s3[D_W-1], ovf: 1'b0};
			pl_s4 <= nmag[LO_W-1:0] * YAW_SCALE;
			ph_s4 <= nmag[N_W-1:LO_W] * YAW_SCALE;
			dm_s4 <= DW'(dmag) << 8;
		end
	end

	// s5: rounded dividend
	pside_t        ps_s5;
	logic          v_s5;
	logic [DW-1:0] num_s5, dm_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ps_s5  <= ps_s4;
			num_s5 <= (DW'(ph_s4) << LO_W) + DW'(pl_s4) + (dm_s4 >> 1);
			dm_s5  <= dm_s4;
		end
	end

	// s6: range check, then one quotient bit per cell
	pside_t        dps_q [QW+1];
	logic [QW:0]   dv_q;
	logic [DW-1:0] rem_s6, dm_s6;
	logic [DW-1:0] drem [QW];
	logic [DW-1:0] ddm [QW];
	logic [QW-1:0] dq [QW];
	pside_t        ps6_nxt;

	always_comb begin
		ps6_nxt     = ps_s5;
		ps6_nxt.ovf = num_s5 >= (dm_s5 << QW);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s6   <= num_s5;
			dm_s6    <= dm_s5;
			dps_q[0] <= ps6_nxt;
			for (int j = 1; j <= QW; j++) dps_q[j] <= dps_q[j-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			dv_q <= '0;
		end else if (en) begin
			v_s1 <= cv_q[CORDIC_STAGES];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			dv_q <= {dv_q[QW-1:0], v_s5};
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		if (j == 0) begin : g_first
			sbv_div_cell #(.BIT(QW-1-j)) u_cell (
				.clk(clk), .en(en), .rem_i(rem_s6), .dm_i(dm_s6), .q_i('0),
				.rem_o(drem[j]), .dm_o(ddm[j]), .q_o(dq[j])
			);
		end else begin : g_next
			sbv_div_cell #(.BIT(QW-1-j)) u_cell (
				.clk(clk), .en(en), .rem_i(drem[j-1]), .dm_i(ddm[j-1]), .q_i(dq[j-1]),
				.rem_o(drem[j]), .dm_o(ddm[j]), .q_o(dq[j])
			);
		end
	end

	// output word
	pside_t                   pf;
	logic signed [SPIN_W-1:0] qs;
	logic signed [VEL_W-1:0]  vx_n, vy_n;
	logic signed [SPIN_W-1:0] yaw_n;
	logic                     sat_n;

	always_comb begin
		pf    = dps_q[QW];
		qs    = $signed({1'b0, dq[QW-1]});
		vx_n  = pf.vx;
		vy_n  = pf.vy;
		yaw_n = '0;
		sat_n = 1'b0;
		case (pf.mode)
			MODE_FRONT, MODE_AWS: begin
				if (pf.nz) begin
					yaw_n = '0;
				end else if (pf.dz) begin
					yaw_n = pf.nneg ? -YAW_MAX : YAW_MAX;
					sat_n = 1'b1;
				end else if (pf.ovf) begin
					yaw_n = pf.negr ? -YAW_MAX : YAW_MAX;
					sat_n = 1'b1;
				end else begin
					yaw_n = pf.negr ? -qs : qs;
				end
			end
			MODE_CRAB: ;
			MODE_ROTATE: begin
				vx_n = '0;
				vy_n = '0;
				if (pf.spin == YAW_MIN_RAW) begin
					yaw_n = -YAW_MAX;
					sat_n = 1'b1;
				end else begin
					yaw_n = pf.spin;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= dv_q[QW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vel_x     <= vx_n;
			vel_y     <= vy_n;
			yaw_rate  <= yaw_n;
			saturated <= sat_n;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sbv_checker.sv =====
`default_nettype none
module sbv_assert import sbv_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_ready,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic signed [VEL_W-1:0]  vel_x,
	input wire logic signed [VEL_W-1:0]  vel_y,
	input wire logic signed [SPIN_W-1:0] yaw_rate,
	input wire logic                     saturated
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vel_x) && $stable(vel_y)
			&& $stable(yaw_rate) && $stable(saturated))
		else $error("output word changed while held");

	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (yaw_rate == YAW_MAX || yaw_rate == -YAW_MAX))
		else $error("saturated word without clipped yaw");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> yaw_rate != YAW_MIN_RAW)
		else $error("yaw rate out of range");

	a_vel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> vel_x != -VEL_MAX - 17'sd1 && vel_y != -VEL_MAX - 17'sd1)
		else $error("velocity out of range");

	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output held");

endmodule

bind steering_mode_body_velocity sbv_assert u_sbv_assert (.*);
`default_nettype wire

// ===== verif/sbv_checker.sv =====
`timescale 1ns / 1ps
module sbv_checker import sbv_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	input  wire logic                     cfg_ready,
	input  wire logic [IDX_W-1:0]         cfg_index,
	input  wire logic [WB_W-1:0]          cfg_data,
	input  wire logic                     in_valid,
	input  wire logic                     in_ready,
	input  wire logic signed [SPD_W-1:0]  speed,
	input  wire logic signed [ANG_W-1:0]  steer_front,
	input  wire logic signed [ANG_W-1:0]  steer_rear,
	input  wire logic signed [ANG_W-1:0]  slip_angle,
	input  wire logic signed [HDG_W-1:0]  heading,
	input  wire logic signed [HDG_W-1:0]  travel_direction,
	input  wire logic signed [SPIN_W-1:0] spin_rate,
	input  wire logic                     out_valid,
	input  wire logic                     out_ready,
	input  wire logic signed [VEL_W-1:0]  vel_x,
	input  wire logic signed [VEL_W-1:0]  vel_y,
	input  wire logic signed [SPIN_W-1:0] yaw_rate,
	input  wire logic                     saturated,
	output int                            fail_count,
	output int                            pending
);

	typedef struct packed {
		logic signed [VEL_W-1:0]  vx;
		logic signed [VEL_W-1:0]  vy;
		logic signed [SPIN_W-1:0] yaw;
		logic                     sat;
	} motion_t;

	localparam longint YAW_LIM = 8388607;
	localparam longint VEL_LIM = 65535;

	mode_t          cur_mode;
	logic [WB_W-1:0] cur_wb;
	motion_t        motion_q[$];

	function automatic void sin_cos(input int ang, output longint c, output longint s);
		int r;
		bit fold;
		longint x, y, z, nx;
		r = ang % 46080;
		fold = 0;
		if (r >= 23040) r -= 46080;
		if (r < -23040) r += 46080;
		if (r > 11520) begin
			r -= 23040;
			fold = 1;
		end
		if (r < -11520) begin
			r += 23040;
			fold = 1;
		end
		x = 652032874;
		y = 0;
		z = longint'(r) * 256;
		for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(ATAN_TAB[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(ATAN_TAB[i]);
			end
			x = nx;
		end
		c = fold ? -x : x;
		s = fold ? -y : y;
	endfunction

	function automatic longint clamp(input longint v, input longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint scale_vel(input longint spd, input longint f);
		return clamp((spd * f + (longint'(1) <<< 29)) >>> 30, VEL_LIM);
	endfunction

	function automatic longint body_yaw(input longint spd, input int num_ang,
			input int den_ang, input int slip, output bit sat);
		longint cn, sn, cd, sd, cb, sb, n, d;
		longint unsigned nm, dm, q;
		bit negr;
		sin_cos(num_ang, cn, sn);
		sin_cos(den_ang, cd, sd);
		sin_cos(slip, cb, sb);
		n = spd * ((sn * cb + (longint'(1) <<< 35)) >>> 36);
		d = longint'(cur_wb) * ((cd + 32) >>> 6);
		sat = 0;
		if (n == 0) return 0;
		negr = (n < 0) != (d < 0);
		if (d == 0) begin
			sat = 1;
			return n < 0 ? -YAW_LIM : YAW_LIM;
		end
		nm = longint'(n < 0 ? -n : n) * 64'd1877468;
		dm = longint'(d < 0 ? -d : d) * 64'd256;
		q = (nm + dm / 2) / dm;
		if (q > YAW_LIM) begin
			sat = 1;
			q = YAW_LIM;
		end
		return negr ? -longint'(q) : longint'(q);
	endfunction

	function automatic motion_t predict_motion();
		motion_t m;
		longint spd, c, s, yaw, spin;
		int df, dr, sl, rear;
		bit sat;
		spd = speed;
		df = steer_front;
		dr = steer_rear;
		sl = slip_angle;
		spin = spin_rate;
		m = '0;
		case (cur_mode)
			MODE_FRONT, MODE_AWS: begin
				rear = (cur_mode == MODE_AWS) ? dr : 0;
				sin_cos(int'(heading) + rear + sl, c, s);
				m.vx = VEL_W'(scale_vel(spd, c));
				m.vy = VEL_W'(scale_vel(spd, s));
				yaw = body_yaw(spd, df - rear, df, sl, sat);
				m.yaw = SPIN_W'(yaw);
				m.sat = sat;
			end
			MODE_CRAB: begin
				sin_cos(int'(travel_direction), c, s);
				m.vx = VEL_W'(scale_vel(spd, c));
				m.vy = VEL_W'(scale_vel(spd, s));
			end
			default: begin
				yaw = clamp(spin, YAW_LIM);
				m.yaw = SPIN_W'(yaw);
				m.sat = (yaw != spin);
			end
		endcase
		return m;
	endfunction

	assign pending = motion_q.size();

	always @(posedge clk or negedge arst_n) begin
		motion_t exp_m;
		if (!arst_n) begin
			cur_mode <= MODE_FRONT;
			cur_wb <= WHEELBASE_RST;
			fail_count <= 0;
			motion_q.delete();
		end else begin
			if (in_valid && in_ready)
				motion_q.push_back(predict_motion());
			if (out_valid && out_ready) begin
				if (motion_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected output word vx=%0d vy=%0d yaw=%0d sat=%0d",
							vel_x, vel_y, yaw_rate, saturated);
					fail_count <= fail_count + 1;
				end else begin
					exp_m = motion_q.pop_front();
					if (exp_m.vx !== vel_x || exp_m.vy !== vel_y ||
							exp_m.yaw !== yaw_rate || exp_m.sat !== saturated) begin
						if (fail_count < 10)
							$display("mismatch exp vx=%0d vy=%0d yaw=%0d sat=%0d got vx=%0d vy=%0d yaw=%0d sat=%0d",
								exp_m.vx, exp_m.vy, exp_m.yaw, exp_m.sat,
								vel_x, vel_y, yaw_rate, saturated);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MODE)
					cur_mode <= mode_t'(cfg_data[MODE_W-1:0]);
				else if (cfg_index == REG_WHEELBASE)
					cur_wb <= cfg_data;
			end
		end
	end

endmodule

// ===== verif/tb_steering_mode_body_velocity.sv =====
`timescale 1ns / 1ps
module tb_steering_mode_body_velocity import sbv_pkg::*; ();

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [IDX_W-1:0]         cfg_index;
	logic [WB_W-1:0]          cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [SPD_W-1:0]  speed;
	logic signed [ANG_W-1:0]  steer_front;
	logic signed [ANG_W-1:0]  steer_rear;
	logic signed [ANG_W-1:0]  slip_angle;
	logic signed [HDG_W-1:0]  heading;
	logic signed [HDG_W-1:0]  travel_direction;
	logic signed [SPIN_W-1:0] spin_rate;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [VEL_W-1:0]  vel_x;
	logic signed [VEL_W-1:0]  vel_y;
	logic signed [SPIN_W-1:0] yaw_rate;
	logic                     saturated;
	int                       fail_count;
	int                       pending;
	int                       burst_left;
	bit                       long_hold;

	steering_mode_body_velocity dut (.*);
	sbv_checker chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("steering_mode_body_velocity verification failed");
		$finish;
	end

	initial begin
		int pat;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			pat = $urandom_range(0, 2);
			repeat ($urandom_range(10, 60)) begin
				@(posedge clk);
				if (long_hold) begin
					out_ready <= 0;
					repeat (300) @(posedge clk);
					long_hold = 0;
				end
				case (pat)
					0: out_ready <= 1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					default: out_ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WB_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (CORDIC_STAGES_DEF + 40) @(posedge clk);
	endtask

	task automatic send_word(input logic [SPD_W-1:0] spd, input logic [ANG_W-1:0] df,
			input logic [ANG_W-1:0] dr, input logic [ANG_W-1:0] sl,
			input logic [HDG_W-1:0] hd, input logic [HDG_W-1:0] td,
			input logic [SPIN_W-1:0] spin);
		speed <= spd;
		steer_front <= df;
		steer_rear <= dr;
		slip_angle <= sl;
		heading <= hd;
		travel_direction <= td;
		spin_rate <= spin;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	function automatic logic [ANG_W-1:0] rand_angle();
		int k;
		k = $urandom_range(0, 9);
		if (k < 6) return ANG_W'($signed($urandom_range(0, 23040)) - 11520);
		if (k < 8) return ANG_W'($urandom);
		return ($urandom_range(0, 1) == 1) ? ANG_W'(11520) : ANG_W'(-11520);
	endfunction

	function automatic logic [HDG_W-1:0] rand_heading();
		if ($urandom_range(0, 3) != 0)
			return HDG_W'($signed($urandom_range(0, 46080)) - 23040);
		return HDG_W'($urandom);
	endfunction

	function automatic logic [SPD_W-1:0] rand_speed();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) return ($urandom_range(0, 1) == 1) ? SPD_W'(65535) : SPD_W'(-65536);
		if (k < 3) return SPD_W'($signed($urandom_range(0, 400)) - 200);
		return SPD_W'($urandom);
	endfunction

	task automatic directed_words();
		send_word(17'sd65535, 15'sd11520, -15'sd11520, 15'sd0, 16'sd0, 16'sd0, 24'sd8388607);
		send_word(-17'sd65536, -15'sd11520, 15'sd11520, 15'sd11520, 16'sd23040,
			-16'sd23040, -24'sd8388608);
		send_word(-17'sd65535, 15'sd0, 15'sd0, -15'sd11520, -16'sd23040, 16'sd23040, 24'sd0);
		send_word(17'sd0, 15'sd16383, -15'sd16384, 15'sd5760, 16'sd32767, -16'sd32768,
			-24'sd8388607);
		send_word(17'sd1000, 15'sd11519, 15'sd11000, 15'sd0, 16'sd11520, 16'sd11520, 24'sd1);
		send_word(17'sd65535, -15'sd16384, 15'sd16383, -15'sd16384, -16'sd32768,
			16'sd32767, -24'sd1);
	endtask

	initial begin
		int unsigned modes[8] = '{0, 1, 2, 3, 0, 1, 0, 1};
		int unsigned wbs[8] = '{2700, 100, 10000, 16383, 0, 1, 10000, 2700};
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		speed = '0;
		steer_front = '0;
		steer_rear = '0;
		slip_angle = '0;
		heading = '0;
		travel_direction = '0;
		spin_rate = '0;
		long_hold = 0;
		burst_left = 10;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int p = 0; p < 8; p++) begin
			write_reg(REG_MODE, WB_W'(modes[p]));
			write_reg(REG_WHEELBASE, WB_W'(wbs[p]));
			if (p == 2) write_reg(IDX_W'(3), 14'h3FFF);
			if (p < 4) directed_words();
			for (int i = 0; i < 105; i++) begin
				if (p == 3 && i == 20) long_hold = 1;
				send_word(rand_speed(), rand_angle(), rand_angle(), rand_angle(),
					rand_heading(), rand_heading(), SPIN_W'($urandom));
			end
			in_valid <= 0;
			drain();
		end
		if (fail_count == 0)
			$display("steering_mode_body_velocity verification clean");
		else
			$display("steering_mode_body_velocity verification failed");
		$finish;
	end

endmodule
